// File: src/vsp_pkg.sv
// ----------------------------------------------------------------------------
// vsp_pkg: shared types and constants of the version string parser
// Parse state, decoded character beat and result record, plus the codes
// of the text regions and of the per-component phases.
// ----------------------------------------------------------------------------
package vsp_pkg;

  localparam int VAL_W  = 31;
  localparam int CODE_W = 21;

  // text regions
  localparam logic [1:0] RG_LEAD    = 2'd0;
  localparam logic [1:0] RG_BODY    = 2'd1;
  localparam logic [1:0] RG_WS      = 2'd2;
  localparam logic [1:0] RG_WS_WIDE = 2'd3;

  // component phases
  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_TRAIL  = 3'd3;
  localparam logic [2:0] PH_NUL    = 3'd4;

  localparam logic [1:0] PART_MAJOR = 2'd0;
  localparam logic [1:0] PART_MINOR = 2'd1;
  localparam logic [1:0] PART_BUILD = 2'd2;
  localparam logic [1:0] PART_LAST  = 2'd3;

  // character codes
  localparam logic [7:0] CHR_NUL     = 8'h00;
  localparam logic [7:0] CHR_TAB     = 8'h09;
  localparam logic [7:0] CHR_CR      = 8'h0D;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_PLUS    = 8'h2B;
  localparam logic [7:0] CHR_MINUS   = 8'h2D;
  localparam logic [7:0] CHR_DOT     = 8'h2E;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_UPPER_V = 8'h56;
  localparam logic [7:0] CHR_LOWER_V = 8'h76;

  localparam logic [CODE_W-1:0] CP_ASCII_END = 21'h000080;
  localparam logic [CODE_W-1:0] CP_MIN_3B    = 21'h000800;
  localparam logic [CODE_W-1:0] CP_MIN_4B    = 21'h010000;
  localparam logic [CODE_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CODE_W-1:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [CODE_W-1:0] CP_SURR_HI   = 21'h00DFFF;

  // value limit 2147483647 split as 214748364 * 10 + 7
  localparam logic [VAL_W-1:0] LIMIT_DIV10 = 31'd214748364;
  localparam logic [3:0]       LIMIT_MOD10 = 4'd7;

  typedef struct packed {
    logic [1:0]        rem;
    logic [CODE_W-1:0] code;
    logic [1:0]        lclass;
  } utf8_t;

  typedef struct packed {
    logic              valid;
    logic              fail;
    logic [CODE_W-1:0] code;
  } char_t;

  typedef struct packed {
    logic [1:0]       region;
    logic [1:0]       pidx;
    logic [2:0]       phase;
    logic [VAL_W-1:0] pval;
    logic [VAL_W-1:0] major;
    logic [VAL_W-1:0] minor;
    logic [VAL_W-1:0] build;
    logic             bpres;
    logic             failed;
  } parse_t;

  typedef struct packed {
    logic             accepted;
    logic [VAL_W-1:0] major;
    logic [VAL_W-1:0] minor;
    logic [VAL_W-1:0] build;
  } res_t;

  localparam utf8_t  UTF8_RESET  = '{rem: 2'd0, code: '0, lclass: 2'd0};
  localparam parse_t PARSE_RESET = '{region: RG_LEAD, pidx: PART_MAJOR, phase: PH_LEAD,
                                     pval: '0, major: '0, minor: '0, build: '0,
                                     bpres: 1'b0, failed: 1'b0};

endpackage

// File: src/vsp_utf8.sv
// ----------------------------------------------------------------------------
// vsp_utf8: UTF-8 byte decoder
// Assembles multibyte sequences and flags stray continuation bytes,
// invalid leads, cut-short sequences, overlong forms, surrogates and values above the range.
// ----------------------------------------------------------------------------
module vsp_utf8 (
  input  logic [7:0]     text_byte,
  input  vsp_pkg::utf8_t utf8_cur,
  output vsp_pkg::utf8_t utf8_next,
  output vsp_pkg::char_t char_out
);

  logic [vsp_pkg::CODE_W-1:0] code_cont;
  logic [vsp_pkg::CODE_W-1:0] lowest;
  logic [1:0]                 rem_dec;

  assign code_cont = {utf8_cur.code[vsp_pkg::CODE_W-7:0], text_byte[5:0]};
  assign rem_dec   = utf8_cur.rem - 2'd1;

  always_comb begin
    unique case (utf8_cur.lclass)
      2'd1:    lowest = vsp_pkg::CP_ASCII_END;
      2'd2:    lowest = vsp_pkg::CP_MIN_3B;
      default: lowest = vsp_pkg::CP_MIN_4B;
    endcase
  end

  always_comb begin
    utf8_next     = utf8_cur;
    char_out      = '0;
    if (utf8_cur.rem != 2'd0) begin
      if (text_byte[7:6] != 2'b10) begin
        char_out.fail = 1'b1;
      end else begin
        utf8_next.code = code_cont;
        utf8_next.rem  = rem_dec;
        if (rem_dec == 2'd0) begin
          if (code_cont < lowest || code_cont > vsp_pkg::CP_MAX ||
              (code_cont >= vsp_pkg::CP_SURR_LO && code_cont <= vsp_pkg::CP_SURR_HI)) begin
            char_out.fail = 1'b1;
          end else begin
            char_out.valid = 1'b1;
            char_out.code  = code_cont;
          end
        end
      end
    end else if (text_byte[7] == 1'b0) begin
      char_out.valid = 1'b1;
      char_out.code  = {13'd0, text_byte};
    end else if (text_byte[7:5] == 3'b110) begin
      utf8_next = '{rem: 2'd1, code: {16'd0, text_byte[4:0]}, lclass: 2'd1};
    end else if (text_byte[7:4] == 4'b1110) begin
      utf8_next = '{rem: 2'd2, code: {17'd0, text_byte[3:0]}, lclass: 2'd2};
    end else if (text_byte[7:3] == 5'b11110) begin
      utf8_next = '{rem: 2'd3, code: {18'd0, text_byte[2:0]}, lclass: 2'd3};
    end else begin
      char_out.fail = 1'b1;
    end
  end

endmodule

// File: src/vsp_char.sv
// ----------------------------------------------------------------------------
// vsp_char: character step of the parser
// Trims outer whitespace, skips a leading v, and runs the per-component
// phase machine with its decimal accumulator.
// ----------------------------------------------------------------------------
module vsp_char (
  input  vsp_pkg::parse_t parse_cur,
  input  vsp_pkg::char_t  char_in,
  output vsp_pkg::parse_t parse_next
);

  function automatic logic ascii_space(logic [vsp_pkg::CODE_W-1:0] c);
    return c == {13'd0, vsp_pkg::CHR_SPACE} ||
           (c >= {13'd0, vsp_pkg::CHR_TAB} && c <= {13'd0, vsp_pkg::CHR_CR});
  endfunction

  function automatic logic unicode_space(logic [vsp_pkg::CODE_W-1:0] c);
    return ascii_space(c) || c == 21'h85 || c == 21'hA0 || c == 21'h1680 ||
           (c >= 21'h2000 && c <= 21'h200A) || c == 21'h2028 || c == 21'h2029 ||
           c == 21'h202F || c == 21'h205F || c == 21'h3000;
  endfunction

  function automatic vsp_pkg::parse_t add_digit(vsp_pkg::parse_t s, logic [3:0] d);
    vsp_pkg::parse_t r;
    logic [33:0]     prod;
    r    = s;
    prod = {s.pval, 3'd0} + {2'd0, s.pval, 1'b0} + {30'd0, d};
    if (s.pval > vsp_pkg::LIMIT_DIV10 ||
        (s.pval == vsp_pkg::LIMIT_DIV10 && d > vsp_pkg::LIMIT_MOD10)) begin
      r.failed = 1'b1;
    end else begin
      r.pval  = prod[vsp_pkg::VAL_W-1:0];
      r.phase = vsp_pkg::PH_DIGITS;
    end
    return r;
  endfunction

  function automatic vsp_pkg::parse_t next_part(vsp_pkg::parse_t s);
    vsp_pkg::parse_t r;
    r = s;
    if (s.pidx == vsp_pkg::PART_LAST) begin
      r.failed = 1'b1;
    end else begin
      case (s.pidx)
        vsp_pkg::PART_MAJOR: r.major = s.pval;
        vsp_pkg::PART_MINOR: r.minor = s.pval;
        default: begin
          r.build = s.pval;
          r.bpres = 1'b1;
        end
      endcase
      r.pidx  = s.pidx + 2'd1;
      r.phase = vsp_pkg::PH_LEAD;
      r.pval  = '0;
    end
    return r;
  endfunction

  function automatic vsp_pkg::parse_t feed_part(vsp_pkg::parse_t s, logic [7:0] c);
    vsp_pkg::parse_t r;
    logic            digit;
    logic            ws;
    logic            nul;
    logic            dot;
    logic            bad;
    logic [7:0]      dval;
    r     = s;
    bad   = 1'b0;
    digit = c >= vsp_pkg::CHR_ZERO && c <= vsp_pkg::CHR_NINE;
    ws    = ascii_space({13'd0, c});
    nul   = c == vsp_pkg::CHR_NUL;
    dot   = c == vsp_pkg::CHR_DOT;
    dval  = c - vsp_pkg::CHR_ZERO;
    unique case (s.phase)
      vsp_pkg::PH_LEAD: begin
        if (ws) r = s;
        else if (c == vsp_pkg::CHR_PLUS) r.phase = vsp_pkg::PH_SIGN;
        else if (digit) r = add_digit(s, dval[3:0]);
        else bad = 1'b1;
      end
      vsp_pkg::PH_SIGN: begin
        if (digit) r = add_digit(s, dval[3:0]);
        else bad = 1'b1;
      end
      vsp_pkg::PH_DIGITS: begin
        if (digit) r = add_digit(s, dval[3:0]);
        else if (ws) r.phase = vsp_pkg::PH_TRAIL;
        else if (nul) r.phase = vsp_pkg::PH_NUL;
        else if (dot) r = next_part(s);
        else bad = 1'b1;
      end
      vsp_pkg::PH_TRAIL: begin
        if (ws) r = s;
        else if (nul) r.phase = vsp_pkg::PH_NUL;
        else if (dot) r = next_part(s);
        else bad = 1'b1;
      end
      vsp_pkg::PH_NUL: begin
        if (nul) r = s;
        else if (dot) r = next_part(s);
        else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) r.failed = 1'b1;
    return r;
  endfunction

  function automatic vsp_pkg::parse_t body_char(vsp_pkg::parse_t s,
                                                logic [vsp_pkg::CODE_W-1:0] c);
    vsp_pkg::parse_t r;
    r = s;
    if (c >= vsp_pkg::CP_ASCII_END || c == {13'd0, vsp_pkg::CHR_MINUS}) begin
      r.failed = 1'b1;
    end else begin
      r = feed_part(s, c[7:0]);
    end
    return r;
  endfunction

  logic            ws;
  logic            wide;
  logic            is_v;
  vsp_pkg::parse_t flushed;

  assign ws      = unicode_space(char_in.code);
  assign wide    = char_in.code >= vsp_pkg::CP_ASCII_END;
  assign is_v    = char_in.code == {13'd0, vsp_pkg::CHR_LOWER_V} ||
                   char_in.code == {13'd0, vsp_pkg::CHR_UPPER_V};
  // pending ASCII whitespace turns into one space for the component
  assign flushed = feed_part(parse_cur, vsp_pkg::CHR_SPACE);

  always_comb begin
    parse_next = parse_cur;
    if (char_in.fail) begin
      parse_next.failed = 1'b1;
    end else if (char_in.valid) begin
      unique case (parse_cur.region)
        vsp_pkg::RG_LEAD: begin
          if (!ws) begin
            parse_next.region = vsp_pkg::RG_BODY;
            if (!is_v) parse_next = body_char(parse_next, char_in.code);
          end
        end
        vsp_pkg::RG_BODY: begin
          if (ws) parse_next.region = wide ? vsp_pkg::RG_WS_WIDE : vsp_pkg::RG_WS;
          else parse_next = body_char(parse_cur, char_in.code);
        end
        vsp_pkg::RG_WS: begin
          if (ws) begin
            if (wide) parse_next.region = vsp_pkg::RG_WS_WIDE;
          end else begin
            parse_next        = flushed;
            parse_next.region = vsp_pkg::RG_BODY;
            if (!flushed.failed) parse_next = body_char(parse_next, char_in.code);
          end
        end
        default: begin
          if (!ws) parse_next.failed = 1'b1;
        end
      endcase
    end
  end

endmodule

// File: src/vsp_check.sv
// ----------------------------------------------------------------------------
// vsp_check: end-of-text verdict
// Stores the open component and decides whether the text is a release
// version; a rejected text reports all numbers as zero.
// ----------------------------------------------------------------------------
module vsp_check (
  input  vsp_pkg::parse_t parse_in,
  input  logic            utf8_open,
  output vsp_pkg::res_t   res_out
);

  logic [vsp_pkg::VAL_W-1:0] major;
  logic [vsp_pkg::VAL_W-1:0] minor;
  logic [vsp_pkg::VAL_W-1:0] build;
  logic                      bpres;
  logic                      ok;

  always_comb begin
    major = parse_in.major;
    minor = parse_in.minor;
    build = parse_in.build;
    bpres = parse_in.bpres;
    case (parse_in.pidx)
      vsp_pkg::PART_MAJOR: major = parse_in.pval;
      vsp_pkg::PART_MINOR: minor = parse_in.pval;
      vsp_pkg::PART_BUILD: begin
        build = parse_in.pval;
        bpres = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    ok = !parse_in.failed && !utf8_open && parse_in.region != vsp_pkg::RG_LEAD &&
         (parse_in.phase == vsp_pkg::PH_DIGITS || parse_in.phase == vsp_pkg::PH_TRAIL ||
          parse_in.phase == vsp_pkg::PH_NUL) &&
         parse_in.pidx != vsp_pkg::PART_MAJOR;
    // 1.0 with no build or build 0 is not a release
    if (major == 31'd1 && minor == '0 && (!bpres || build == '0)) ok = 1'b0;
    res_out.accepted = ok;
    res_out.major    = ok ? major : '0;
    res_out.minor    = ok ? minor : '0;
    res_out.build    = (ok && bpres) ? build : '0;
  end

endmodule

// File: src/version_string_parser_core.sv
// ----------------------------------------------------------------------------
// version_string_parser_core: streaming version text parser
// Takes a UTF-8 text one byte a beat and gives one verdict beat with the
// major, minor and build numbers when the text ends.
// ----------------------------------------------------------------------------
//   channel | dir | tdata                         | tlast       | tuser
//   in_     | in  | text_byte[7:0]                | end_of_text | no_byte
//   out_    | out | major, minor, build (31 each) | -           | accepted
//
// One byte beat per cycle while the output is not stalled; a beat is
// registered, then decoded and folded into the parse state as it leaves
// the input register, and that edge also loads the verdict of a final
// beat into the output register, which raises out_tvalid. The parse state
// returns to reset after each verdict. Reset is synchronous on rst_n low.
// A stalled output holds the input register, and in_tready drops only
// while both registers are full.
// ----------------------------------------------------------------------------
module version_string_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,
  input  logic        in_tuser,   // [0] no_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [30:0] major, [61:31] minor, [92:62] build, rest 0
  output logic        out_tuser   // [0] accepted
);

  logic            s1_valid_r, s1_valid_nxt;
  logic [7:0]      s1_byte_r;
  logic            s1_last_r;
  logic            s1_none_r;
  logic            out_valid_r, out_valid_nxt;
  vsp_pkg::res_t   res_r;
  vsp_pkg::utf8_t  utf8_r, utf8_nxt;
  vsp_pkg::parse_t parse_r, parse_nxt;

  vsp_pkg::utf8_t  utf8_dec;
  vsp_pkg::char_t  char_dec;
  vsp_pkg::char_t  char_gated;
  vsp_pkg::parse_t parse_step;
  vsp_pkg::utf8_t  utf8_step;
  vsp_pkg::res_t   res_now;
  logic            adv;
  logic            take;
  logic            do_step;

  assign adv       = !out_valid_r || out_tready;
  assign take      = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;
  assign do_step   = !s1_none_r && !parse_r.failed;

  vsp_utf8 u_utf8 (
    .text_byte (s1_byte_r),
    .utf8_cur  (utf8_r),
    .utf8_next (utf8_dec),
    .char_out  (char_dec)
  );

  // drop the byte of an empty beat or of an already rejected text
  always_comb begin
    char_gated = char_dec;
    if (!do_step) char_gated = '0;
  end

  assign utf8_step = do_step ? utf8_dec : utf8_r;

  vsp_char u_char (
    .parse_cur  (parse_r),
    .char_in    (char_gated),
    .parse_next (parse_step)
  );

  vsp_check u_check (
    .parse_in  (parse_step),
    .utf8_open (utf8_step.rem != 2'd0),
    .res_out   (res_now)
  );

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    utf8_nxt      = utf8_r;
    parse_nxt     = parse_r;
    if (in_tready) s1_valid_nxt = in_tvalid;
    if (adv) out_valid_nxt = take && s1_last_r;
    if (take) begin
      if (s1_last_r) begin
        utf8_nxt  = vsp_pkg::UTF8_RESET;
        parse_nxt = vsp_pkg::PARSE_RESET;
      end else begin
        utf8_nxt  = utf8_step;
        parse_nxt = parse_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      utf8_r      <= vsp_pkg::UTF8_RESET;
      parse_r     <= vsp_pkg::PARSE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      utf8_r      <= utf8_nxt;
      parse_r     <= parse_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
      s1_none_r <= in_tuser;
    end
    if (take && s1_last_r) res_r <= res_now;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.accepted;
  assign out_tdata  = {3'd0, res_r.build, res_r.minor, res_r.major};

endmodule
